// File: hw/rtl/eipid_pkg.sv
// ----------------------------------------------------------------------------
// eipid_pkg: shared types for the expert incremental pid block
// Sequencer states, multiply step codes, rule modes, register indexes and
// the packed per-channel state word.
// ----------------------------------------------------------------------------
package eipid_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_GAIN_P      = 3'd0,
    CFG_GAIN_I      = 3'd1,
    CFG_GAIN_D      = 3'd2,
    CFG_DRIVE_FLOOR = 3'd3,
    CFG_DRIVE_CEIL  = 3'd4,
    CFG_BANG_LIMIT  = 3'd5,
    CFG_LARGE_LIMIT = 3'd6,
    CFG_SMALL_LIMIT = 3'd7
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIFF,
    ST_DECIDE,
    ST_MUL,
    ST_ACC,
    ST_CLAMP,
    ST_OUT
  } state_e;

  // multiply steps run on the shared multiplier
  typedef enum logic [2:0] {
    OP_PEC,
    OP_IE,
    OP_DDD,
    OP_PLE,
    OP_SCALE
  } op_e;

  // increment rule chosen for the current beat
  typedef enum logic [1:0] {
    MODE_PI,
    MODE_PID,
    MODE_FLIP
  } mode_e;

  // per-channel state word
  typedef struct packed {
    logic signed [31:0] acc;
    logic signed [31:0] lfb;
    logic signed [31:0] lfd;
    logic signed [31:0] le;
    logic signed [31:0] lec;
  } chan_state_t;

endpackage

// File: hw/rtl/eipid_in_if.sv
// ----------------------------------------------------------------------------
// eipid_in_if: input channel of the expert incremental pid block
// Valid/ready handshake carrying setpoint, feedback, channel and clear.
// ----------------------------------------------------------------------------
interface eipid_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] setpoint;
  logic signed [31:0] feedback;
  logic [1:0]         channel;
  logic               clear;

  modport source (output valid, setpoint, feedback, channel, clear, input ready);
  modport sink   (input valid, setpoint, feedback, channel, clear, output ready);
endinterface

// File: hw/rtl/eipid_out_if.sv
// ----------------------------------------------------------------------------
// eipid_out_if: result channel of the expert incremental pid block
// Valid/ready handshake carrying the clamped drive.
// ----------------------------------------------------------------------------
interface eipid_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;

  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

// File: hw/rtl/expert_incremental_pid_top.sv
// path: a clear beat goes from load straight to the result beat; a beat that needs no
// product (bang or held increment) runs load, diff, decide, clamp and output;
// the pi and sign-flip rules add two products, the pid rule three and the
// boosted pid rule four; throughput: one beat at a time; the next input beat is taken
// the cycle after the result beat leaves, and the one shared 32x32 multiplier
// runs up to four dependent products per beat
// reset: async, sets config registers to defaults, clears sequencer and channel valid bits (state reads 0)
// ----------------------------------------------------------------------------
// expert_incremental_pid_top: multi-channel expert incremental pid, Q16.16
// Forms error, error change and feedback delta, picks an increment by the
// expert rules, accumulates and clamps the drive per channel.
// ----------------------------------------------------------------------------
module expert_incremental_pid_top #(
  parameter int CHANNELS  = 4,
  parameter int BOOST_Q16 = 131072,
  parameter int DAMP_Q16  = 32768
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [31:0]      cfg_data_i,
  eipid_in_if.sink         in_i,
  eipid_out_if.source      out_o
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // saturate a 33-bit difference to 32 bits
  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] == d[31]) return d[31:0];
    return d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  // saturate a 50-bit sum to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v[49:31] == {19{v[49]}}) return v[31:0];
    return v[49] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  // configuration registers
  logic signed [31:0] gain_p_q, gain_i_q, gain_d_q, floor_q, ceil_q;
  logic [30:0]        bang_q, large_q, small_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= '0;
      gain_i_q <= '0;
      gain_d_q <= '0;
      floor_q  <= 32'sh8000_0000;
      ceil_q   <= 32'sh7fff_ffff;
      bang_q   <= '1;
      large_q  <= '1;
      small_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (eipid_pkg::cfg_idx_e'(cfg_idx_i))
        eipid_pkg::CFG_GAIN_P:      gain_p_q <= cfg_data_i;
        eipid_pkg::CFG_GAIN_I:      gain_i_q <= cfg_data_i;
        eipid_pkg::CFG_GAIN_D:      gain_d_q <= cfg_data_i;
        eipid_pkg::CFG_DRIVE_FLOOR: floor_q  <= cfg_data_i;
        eipid_pkg::CFG_DRIVE_CEIL:  ceil_q   <= cfg_data_i;
        eipid_pkg::CFG_BANG_LIMIT:  bang_q   <= cfg_data_i[30:0];
        eipid_pkg::CFG_LARGE_LIMIT: large_q  <= cfg_data_i[30:0];
        eipid_pkg::CFG_SMALL_LIMIT: small_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  eipid_pkg::state_e state_q, state_d;
  logic in_acc, out_acc;

  assign in_i.ready  = (state_q == eipid_pkg::ST_IDLE);
  assign out_o.valid = (state_q == eipid_pkg::ST_OUT);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_acc     = out_o.valid && out_o.ready;

  // latched input beat
  logic signed [31:0] sp_q, fb_q;
  logic [1:0]         ch_q;
  logic               clr_q;
  logic [CH_W-1:0]    in_addr, addr;
  logic               in_range;

  assign in_addr  = CH_W'(in_i.channel);
  assign addr     = CH_W'(ch_q);
  assign in_range = ({30'd0, ch_q} < 32'(CHANNELS));

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sp_q  <= in_i.setpoint;
      fb_q  <= in_i.feedback;
      ch_q  <= in_i.channel;
      clr_q <= in_i.clear;
    end
  end

  // channel state memory with per-channel valid bits
  eipid_pkg::chan_state_t st_mem [CHANNELS];
  eipid_pkg::chan_state_t rd_q, cur, wr_word;
  logic [CHANNELS-1:0]    vld_q;
  logic                   rd_vld_q;
  logic signed [31:0]     clamp_val;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= st_mem[in_addr];
    end
    if (state_q == eipid_pkg::ST_CLAMP) begin
      st_mem[addr] <= wr_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        rd_vld_q <= vld_q[in_addr];
      end
      if (state_q == eipid_pkg::ST_LOAD && in_range && clr_q) begin
        vld_q[addr] <= 1'b0;
      end else if (state_q == eipid_pkg::ST_CLAMP) begin
        vld_q[addr] <= 1'b1;
      end
    end
  end

  // a never-written or cleared channel reads as zero
  assign cur = rd_vld_q ? rd_q : '0;

  // differences and rule flags
  logic signed [31:0] e_q, fd_q, ec_q, dd_q;
  logic [31:0]        mag_q;
  logic signed [32:0] neg_bang;
  logic               is_small, is_big, same_sgn, flip_sgn;
  logic signed [31:0] bang_inc;

  assign neg_bang = -$signed({2'b00, bang_q});
  assign is_small = (mag_q < {1'b0, small_q});
  assign is_big   = (mag_q > {1'b0, large_q});
  assign same_sgn = (e_q > 0 && ec_q > 0) || (e_q < 0 && ec_q < 0) || (ec_q == 0);
  assign flip_sgn = ((ec_q > 0 && cur.lec < 0) || (ec_q < 0 && cur.lec > 0)) && (e_q != 0);

  always_comb begin
    if ($signed({e_q[31], e_q}) < neg_bang) begin
      bang_inc = floor_q;
    end else if ($signed({e_q[31], e_q}) > $signed({2'b00, bang_q})) begin
      bang_inc = ceil_q;
    end else begin
      bang_inc = '0;
    end
  end

  // shared multiplier and accumulator
  eipid_pkg::op_e     op_q;
  eipid_pkg::mode_e   mode_q;
  logic               big_q;
  logic signed [31:0] mul_a, mul_b, inc_q, scale;
  logic signed [63:0] prod_q;
  logic signed [47:0] rnd;
  logic signed [49:0] acc_q, acc_sum;
  logic signed [31:0] acc_sat;

  assign scale = (mode_q == eipid_pkg::MODE_FLIP && !big_q) ? 32'(DAMP_Q16) : 32'(BOOST_Q16);

  always_comb begin
    case (op_q)
      eipid_pkg::OP_PEC: begin
        mul_a = gain_p_q; mul_b = ec_q;
      end
      eipid_pkg::OP_IE: begin
        mul_a = gain_i_q; mul_b = e_q;
      end
      eipid_pkg::OP_DDD: begin
        mul_a = gain_d_q; mul_b = dd_q;
      end
      eipid_pkg::OP_PLE: begin
        mul_a = gain_p_q; mul_b = cur.le;
      end
      default: begin
        mul_a = inc_q; mul_b = scale;
      end
    endcase
  end

  // round half up: floor(p / 2^16) plus bit 15
  assign rnd     = $signed(prod_q[63:16]) + $signed({47'd0, prod_q[15]});
  assign acc_sum = acc_q + {{2{rnd[47]}}, rnd};
  assign acc_sat = sat32(acc_sum);

  // clamp of accumulated drive
  logic signed [32:0] drv_sum;
  assign drv_sum = {cur.acc[31], cur.acc} + {inc_q[31], inc_q};

  always_comb begin
    if (drv_sum < $signed({floor_q[31], floor_q})) begin
      clamp_val = floor_q;
    end else if (drv_sum > $signed({ceil_q[31], ceil_q})) begin
      clamp_val = ceil_q;
    end else begin
      clamp_val = drv_sum[31:0];
    end
  end

  assign wr_word = '{acc: clamp_val, lfb: fb_q, lfd: fd_q, le: e_q, lec: ec_q};

  // output register
  logic signed [31:0] drive_q;
  assign out_o.drive = drive_q;

  // datapath registers stepped by the sequencer
  always_ff @(posedge clk_i) begin
    case (state_q)
      eipid_pkg::ST_LOAD: begin
        e_q     <= sub_sat(sp_q, fb_q);
        fd_q    <= sub_sat(cur.lfb, fb_q);
        drive_q <= '0;
      end
      eipid_pkg::ST_DIFF: begin
        ec_q  <= sub_sat(e_q, cur.le);
        dd_q  <= sub_sat(fd_q, cur.lfd);
        mag_q <= e_q[31] ? 32'(-e_q) : e_q;
      end
      eipid_pkg::ST_DECIDE: begin
        acc_q <= '0;
        big_q <= is_big;
        inc_q <= bang_inc;
        if (is_small) begin
          mode_q <= eipid_pkg::MODE_PI;
          op_q   <= eipid_pkg::OP_PEC;
        end else if (same_sgn) begin
          mode_q <= eipid_pkg::MODE_PID;
          op_q   <= eipid_pkg::OP_PEC;
        end else begin
          mode_q <= eipid_pkg::MODE_FLIP;
          op_q   <= eipid_pkg::OP_PLE;
        end
      end
      eipid_pkg::ST_MUL: begin
        prod_q <= mul_a * mul_b;
      end
      eipid_pkg::ST_ACC: begin
        case (op_q) inside
          eipid_pkg::OP_PEC: begin
            acc_q <= acc_sum;
            op_q  <= eipid_pkg::OP_IE;
          end
          eipid_pkg::OP_IE: begin
            acc_q <= acc_sum;
            inc_q <= acc_sat;
            op_q  <= eipid_pkg::OP_DDD;
          end
          eipid_pkg::OP_DDD, eipid_pkg::OP_PLE: begin
            acc_q <= '0;
            inc_q <= acc_sat;
            op_q  <= eipid_pkg::OP_SCALE;
          end
          default: begin
            inc_q <= acc_sat;
          end
        endcase
      end
      eipid_pkg::ST_CLAMP: begin
        drive_q <= clamp_val;
      end
      default: ;
    endcase
  end

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= eipid_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      eipid_pkg::ST_IDLE: begin
        if (in_acc) state_d = eipid_pkg::ST_LOAD;
      end
      eipid_pkg::ST_LOAD: begin
        state_d = (!in_range || clr_q) ? eipid_pkg::ST_OUT : eipid_pkg::ST_DIFF;
      end
      eipid_pkg::ST_DIFF: begin
        state_d = eipid_pkg::ST_DECIDE;
      end
      eipid_pkg::ST_DECIDE: begin
        state_d = (is_small || same_sgn || flip_sgn) ? eipid_pkg::ST_MUL
                                                     : eipid_pkg::ST_CLAMP;
      end
      eipid_pkg::ST_MUL: begin
        state_d = eipid_pkg::ST_ACC;
      end
      eipid_pkg::ST_ACC: begin
        case (op_q)
          eipid_pkg::OP_PEC: state_d = eipid_pkg::ST_MUL;
          eipid_pkg::OP_IE: begin
            state_d = (mode_q == eipid_pkg::MODE_PID) ? eipid_pkg::ST_MUL
                                                      : eipid_pkg::ST_CLAMP;
          end
          eipid_pkg::OP_DDD: state_d = big_q ? eipid_pkg::ST_MUL : eipid_pkg::ST_CLAMP;
          eipid_pkg::OP_PLE: state_d = eipid_pkg::ST_MUL;
          default:           state_d = eipid_pkg::ST_CLAMP;
        endcase
      end
      eipid_pkg::ST_CLAMP: begin
        state_d = eipid_pkg::ST_OUT;
      end
      eipid_pkg::ST_OUT: begin
        if (out_acc) state_d = eipid_pkg::ST_IDLE;
      end
      default: state_d = eipid_pkg::ST_IDLE;
    endcase
  end

endmodule
